// ===== rtl/lrc_pkg.sv =====
// ============================================================================
// lrc_pkg: shared constants and types for the line rectangle clipper
// Widths of the coefficient, product and divider paths, the sideband that
// travels beside the divider pipelines, and the intercept and register codes.
// ============================================================================
package lrc_pkg;

    localparam int COEF_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIM_BITS  = 16;
    localparam int OUT_BITS  = FRAC_BITS + 1;

    // Signed product of a coefficient and a zero-extended dimension.
    localparam int PRD_BITS = COEF_BITS + DIM_BITS + 1;
    // Signed working width for sums and negations of products.
    localparam int PW = COEF_BITS + DIM_BITS + 3;
    // Unsigned divider operand width: |coef| * dimension.
    localparam int DW = COEF_BITS + DIM_BITS;

    // One quotient bit per divider stage, plus the input stage.
    localparam int ITER    = FRAC_BITS + 1;
    localparam int DIV_LAT = ITER + 1;

    localparam logic [OUT_BITS-1:0] ONE_Q = OUT_BITS'(1) << FRAC_BITS;

    localparam logic [DIM_BITS-1:0] WIDTH_RST  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RST = DIM_BITS'(480);

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        CAND_TOP    = 2'd0,
        CAND_BOTTOM = 2'd1,
        CAND_LEFT   = 2'd2,
        CAND_RIGHT  = 2'd3
    } cand_t;

    typedef struct packed
    {
        logic                x_div;
        logic [OUT_BITS-1:0] other;
    } endpoint_t;

    typedef struct packed
    {
        logic      found;
        endpoint_t ep0;
        endpoint_t ep1;
    } side_t;

endpackage

// ===== rtl/lrc_div.sv =====
// ============================================================================
// lrc_div: pipelined fraction divider
// Computes round(num * 2^FRAC_BITS / den) for num <= den, one restoring
// quotient bit per stage, with a saturated result of one when num >= den.
// ============================================================================
module lrc_div
    import lrc_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [DW-1:0]       num,
    input  logic [DW-1:0]       den,
    output logic [OUT_BITS-1:0] quo
);

    logic [DW-1:0]   r_reg   [0:ITER-1];
    logic [DW-1:0]   d_reg   [0:ITER-1];
    logic [ITER-1:0] q_reg   [1:ITER];
    logic            sat_reg [1:ITER];

    logic [DW-1:0]   r_next  [0:ITER-2];
    logic [ITER-1:0] ge;

    always_comb
    begin
        logic [DW:0] rs;
        for (int i = 0; i < ITER; i++)
        begin
            rs    = {r_reg[i], 1'b0};
            ge[i] = rs >= {1'b0, d_reg[i]};
        end
        for (int i = 0; i < ITER - 1; i++)
        begin
            rs        = {r_reg[i], 1'b0};
            r_next[i] = ge[i] ? DW'(rs - {1'b0, d_reg[i]}) : rs[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= num;
            d_reg[0] <= den;
            for (int i = 1; i < ITER; i++)
            begin
                r_reg[i] <= r_next[i-1];
                d_reg[i] <= d_reg[i-1];
            end
            q_reg[1]   <= ITER'(ge[0]);
            sat_reg[1] <= r_reg[0] >= d_reg[0];
            for (int i = 2; i <= ITER; i++)
            begin
                q_reg[i]   <= {q_reg[i-1][ITER-2:0], ge[i-1]};
                sat_reg[i] <= sat_reg[i-1];
            end
        end
    end

    // Round to nearest, ties up: add half an LSB and drop the guard bit.
    logic [ITER:0] q_round;
    assign q_round = {1'b0, q_reg[ITER]} + (ITER + 1)'(1);
    assign quo     = sat_reg[ITER] ? ONE_Q : q_round[ITER:1];

endmodule

// ===== rtl/line_rectangle_clip.sv =====
// ============================================================================
// line_rectangle_clip: clips a*x + b*y + c = 0 to the configured rectangle
// Finds the first two of the top, bottom, left and right intercepts that lie
// on the rectangle (or the single x of a vertical line) and returns both
// endpoints as normalised Q1.16 values, with y given as 1 - y/height.
// ============================================================================
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  line in   in_valid, in_ready, coef_a/b/c            request in
//  clip out  out_valid, out_ready, found, start/end    request out
//  config    cfg_wr_en, cfg_index, cfg_wdata           write only
//
// Each line passes 23 register stages (4 + (FRAC_BITS + 2) + 1), of which
// the middle (FRAC_BITS + 2) are the two restoring dividers, and a new
// request is taken every cycle unless the output stalls.
// Reset clears every stage's valid bit and loads the 640 by 480 rectangle.
// An output stall freezes all stages at once, so nothing is lost or
// repeated; in_ready is low only while an untaken result request waits.
//
module line_rectangle_clip
    import lrc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [DIM_BITS-1:0]         cfg_wdata,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COEF_BITS-1:0] coef_a,
    input  logic signed [COEF_BITS-1:0] coef_b,
    input  logic signed [COEF_BITS-1:0] coef_c,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [OUT_BITS-1:0]         start_x,
    output logic [OUT_BITS-1:0]         start_y,
    output logic [OUT_BITS-1:0]         end_x,
    output logic [OUT_BITS-1:0]         end_y
);

    localparam int NV = 4 + DIV_LAT + 1;

    // ------------------------------------------------------------------
    // Configuration registers. A zero dimension behaves as one.
    // ------------------------------------------------------------------
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    logic [DIM_BITS-1:0] w_eff;
    logic [DIM_BITS-1:0] h_eff;
    assign w_eff = (width_reg  == '0) ? DIM_BITS'(1) : width_reg;
    assign h_eff = (height_reg == '0) ? DIM_BITS'(1) : height_reg;

    // ------------------------------------------------------------------
    // Valid bits and the global advance. All stages move together.
    // ------------------------------------------------------------------
    logic [NV-1:0] vld_reg;
    logic          adv;

    assign adv      = !vld_reg[NV-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NV-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the three products a*w, b*h and a*(w-1).
    // ------------------------------------------------------------------
    logic signed [COEF_BITS-1:0] a1_reg, b1_reg, c1_reg;
    logic signed [PRD_BITS-1:0]  aw1_reg, bh1_reg, awm1_reg;

    logic signed [DIM_BITS:0] w_s, h_s, wm_s;
    assign w_s  = $signed({1'b0, w_eff});
    assign h_s  = $signed({1'b0, h_eff});
    assign wm_s = $signed({1'b0, w_eff - DIM_BITS'(1)});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg   <= coef_a;
            b1_reg   <= coef_b;
            c1_reg   <= coef_c;
            aw1_reg  <= coef_a * w_s;
            bh1_reg  <= coef_b * h_s;
            awm1_reg <= coef_a * wm_s;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes of the products, the two offset sums, signs and zero flags.
    // ------------------------------------------------------------------
    logic [DW-1:0]        aw2_reg, bh2_reg, awm2_reg;
    logic signed [PW-1:0] c2_reg, sb2_reg, sr2_reg;
    logic                 a_neg2_reg, b_neg2_reg, a_zero2_reg, b_zero2_reg;

    logic signed [PW-1:0] aw_x, bh_x, awm_x, c_x;
    assign aw_x  = PW'(aw1_reg);
    assign bh_x  = PW'(bh1_reg);
    assign awm_x = PW'(awm1_reg);
    assign c_x   = PW'(c1_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aw2_reg     <= DW'(aw_x[PW-1] ? -aw_x : aw_x);
            bh2_reg     <= DW'(bh_x[PW-1] ? -bh_x : bh_x);
            awm2_reg    <= DW'(awm_x[PW-1] ? -awm_x : awm_x);
            c2_reg      <= c_x;
            sb2_reg     <= bh_x + c_x;
            sr2_reg     <= aw_x + c_x;
            a_neg2_reg  <= a1_reg[COEF_BITS-1];
            b_neg2_reg  <= b1_reg[COEF_BITS-1];
            a_zero2_reg <= (a1_reg == '0);
            b_zero2_reg <= (b1_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: numerators with the divisor's sign folded in, so that each
    // intercept reads n / |divisor|.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] nt3_reg, nb3_reg, nl3_reg, nr3_reg;
    logic [DW-1:0]        aw3_reg, bh3_reg, awm3_reg;
    logic                 a_zero3_reg, b_zero3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nt3_reg     <= a_neg2_reg ? c2_reg  : -c2_reg;
            nb3_reg     <= a_neg2_reg ? sb2_reg : -sb2_reg;
            nl3_reg     <= b_neg2_reg ? c2_reg  : -c2_reg;
            nr3_reg     <= b_neg2_reg ? sr2_reg : -sr2_reg;
            aw3_reg     <= aw2_reg;
            bh3_reg     <= bh2_reg;
            awm3_reg    <= awm2_reg;
            a_zero3_reg <= a_zero2_reg;
            b_zero3_reg <= b_zero2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: range tests, and the dividend of each candidate. For the
    // side edges the dividend is (|b|*h - n), which gives 1 - y/h directly.
    // ------------------------------------------------------------------
    logic [DW-1:0] num4_reg [0:3];
    logic [3:0]    ok4_reg;
    logic          okv4_reg, b_zero4_reg;
    logic [DW-1:0] aw4_reg, bh4_reg;

    logic signed [PW-1:0] aw_lim, bh_lim, awm_lim;
    assign aw_lim  = $signed({{(PW-DW){1'b0}}, aw3_reg});
    assign bh_lim  = $signed({{(PW-DW){1'b0}}, bh3_reg});
    assign awm_lim = $signed({{(PW-DW){1'b0}}, awm3_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok4_reg[CAND_TOP]    <= !a_zero3_reg && !nt3_reg[PW-1] && (nt3_reg <= aw_lim);
            ok4_reg[CAND_BOTTOM] <= !a_zero3_reg && !nb3_reg[PW-1] && (nb3_reg <= aw_lim);
            ok4_reg[CAND_LEFT]   <= !b_zero3_reg && !nl3_reg[PW-1] && (nl3_reg <= bh_lim);
            ok4_reg[CAND_RIGHT]  <= !b_zero3_reg && !nr3_reg[PW-1] && (nr3_reg <= bh_lim);
            okv4_reg             <= !a_zero3_reg && !nt3_reg[PW-1] && (nt3_reg <= awm_lim);
            num4_reg[CAND_TOP]    <= nt3_reg[DW-1:0];
            num4_reg[CAND_BOTTOM] <= nb3_reg[DW-1:0];
            num4_reg[CAND_LEFT]   <= bh3_reg - nl3_reg[DW-1:0];
            num4_reg[CAND_RIGHT]  <= bh3_reg - nr3_reg[DW-1:0];
            b_zero4_reg <= b_zero3_reg;
            aw4_reg     <= aw3_reg;
            bh4_reg     <= bh3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5 input: pick the first two accepted intercepts in the order
    // top, bottom, left, right and route them to the two dividers. A
    // vertical line sends the same x to both, at the top and bottom edges.
    // ------------------------------------------------------------------
    logic [DW-1:0] dnum0, dden0, dnum1, dden1;
    side_t         side_in;

    always_comb
    begin
        cand_t sel0, sel1;
        logic  have0, have1;
        sel0  = CAND_TOP;
        sel1  = CAND_TOP;
        have0 = 1'b0;
        have1 = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (ok4_reg[k])
            begin
                if (!have0)
                begin
                    sel0  = cand_t'(k);
                    have0 = 1'b1;
                end
                else if (!have1)
                begin
                    sel1  = cand_t'(k);
                    have1 = 1'b1;
                end
            end
        end

        if (b_zero4_reg)
        begin
            dnum0             = num4_reg[CAND_TOP];
            dden0             = aw4_reg;
            dnum1             = num4_reg[CAND_TOP];
            dden1             = aw4_reg;
            side_in.found     = okv4_reg;
            side_in.ep0.x_div = 1'b1;
            side_in.ep0.other = ONE_Q;
            side_in.ep1.x_div = 1'b1;
            side_in.ep1.other = '0;
        end
        else
        begin
            dnum0 = num4_reg[sel0];
            dnum1 = num4_reg[sel1];
            dden0 = (sel0 == CAND_TOP || sel0 == CAND_BOTTOM) ? aw4_reg : bh4_reg;
            dden1 = (sel1 == CAND_TOP || sel1 == CAND_BOTTOM) ? aw4_reg : bh4_reg;
            side_in.found     = have1;
            side_in.ep0.x_div = (sel0 == CAND_TOP || sel0 == CAND_BOTTOM);
            side_in.ep0.other = (sel0 == CAND_TOP || sel0 == CAND_RIGHT) ? ONE_Q : '0;
            side_in.ep1.x_div = (sel1 == CAND_TOP || sel1 == CAND_BOTTOM);
            side_in.ep1.other = (sel1 == CAND_TOP || sel1 == CAND_RIGHT) ? ONE_Q : '0;
        end
    end

    // ------------------------------------------------------------------
    // Divider pipelines, with the sideband delayed to match.
    // ------------------------------------------------------------------
    logic [OUT_BITS-1:0] quo0, quo1;

    lrc_div u_div0
    (
        .clk (clk),
        .en  (adv),
        .num (dnum0),
        .den (dden0),
        .quo (quo0)
    );

    lrc_div u_div1
    (
        .clk (clk),
        .en  (adv),
        .num (dnum1),
        .den (dden1),
        .quo (quo1)
    );

    side_t side_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. Each quotient lands in x or y as its endpoint needs;
    // a line that misses the rectangle reports all zeros.
    // ------------------------------------------------------------------
    side_t               side_l;
    logic                found_reg;
    logic [OUT_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    assign side_l = side_reg[DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            found_reg <= side_l.found;
            if (side_l.found)
            begin
                sx_reg <= side_l.ep0.x_div ? quo0 : side_l.ep0.other;
                sy_reg <= side_l.ep0.x_div ? side_l.ep0.other : quo0;
                ex_reg <= side_l.ep1.x_div ? quo1 : side_l.ep1.other;
                ey_reg <= side_l.ep1.x_div ? side_l.ep1.other : quo1;
            end
            else
            begin
                sx_reg <= '0;
                sy_reg <= '0;
                ex_reg <= '0;
                ey_reg <= '0;
            end
        end
    end

    assign out_valid = vld_reg[NV-1];
    assign found     = found_reg;
    assign start_x   = sx_reg;
    assign start_y   = sy_reg;
    assign end_x     = ex_reg;
    assign end_y     = ey_reg;

endmodule
